### rtl/assert_macros.svh
// Assertion macros for the RTL, included by optimal_bst_cost.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/obst_pkg.sv
// Constants, types and helpers for the optimal search tree cost block.
package obst_pkg;

	localparam int MAX_KEYS = 32;
	localparam int FREQ_BITS = 16;
	localparam int FREQ_IN_W = 16;
	localparam int COST_W = 26;

	localparam int FREQ_USED_W = (FREQ_BITS < FREQ_IN_W) ? FREQ_BITS : FREQ_IN_W;
	localparam int KEY_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CNT_W = $clog2(MAX_KEYS + 1);
	localparam int PREFIX_W = FREQ_USED_W + KEY_W;
	localparam int CELLS = MAX_KEYS * MAX_KEYS;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [PREFIX_W-1:0] prefix_t;
	typedef logic [COST_W-1:0] cost_t;
	typedef logic [CELL_W-1:0] cell_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_W1,
		ST_W2,
		ST_RL,
		ST_RR,
		ST_RC,
		ST_WR,
		ST_FIN_RD,
		ST_FIN_OUT
	} state_t;

	// Table cell of the interval that starts at key row and ends at key col.
	function automatic cell_t cell_addr(key_t row, key_t col);
		return CELL_W'(int'(row) * MAX_KEYS + int'(col));
	endfunction

endpackage

### rtl/obst_ram.sv
// Generic single write port, single read port RAM with registered read data.
module obst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/optimal_bst_cost.sv
// Optimal binary search tree cost: loads key frequencies, fills the interval table, reports cost.
// Keys load at one per cycle; busy stays low between keys of a set.
// After the last key, busy stays high while the interval table is filled one root at a time,
// paced by the single read port of the interval cost RAM (two reads per root).
// done is high for one cycle, the first cycle in which busy is low; the receiver cannot stall.
// Reset clears the control state only; every table entry whose read value is used is written first.
`include "assert_macros.svh"

module optimal_bst_cost
	import obst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [FREQ_IN_W-1:0] freq_value,
	input  logic                 last_key,
	output logic                 done,
	output logic [COST_W-1:0]    min_cost,
	output logic                 too_many
);

	state_t  state_q, state_d;
	cnt_t    count_q;
	logic    ovf_q;
	prefix_t sum_q;
	cnt_t    len_q;
	key_t    i_q, r_q;
	prefix_t pj_q, weight_q;
	cost_t   left_q, best_q;
	logic    done_q;
	cost_t   min_cost_q;
	logic    too_many_q;

	logic                   accept, room;
	logic [FREQ_USED_W-1:0] freq_used;
	key_t                   key_idx, j;
	cnt_t                   j_full, n_after, end_sum;
	cost_t                  cost_rd, cost_c, best_next;
	prefix_t                prefix_rd;
	logic                   cost_we, prefix_we;
	cell_t                  cost_waddr, cost_raddr;
	cost_t                  cost_wdata;
	key_t                   prefix_raddr;
	prefix_t                prefix_wdata;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign room = (count_q < CNT_W'(MAX_KEYS));
	assign freq_used = freq_value[FREQ_USED_W-1:0];
	assign key_idx = count_q[KEY_W-1:0];
	assign n_after = count_q + CNT_W'(room);
	assign j_full = CNT_W'(i_q) + len_q - CNT_W'(1);
	assign j = j_full[KEY_W-1:0];
	assign end_sum = CNT_W'(i_q) + len_q;

	assign cost_c = left_q + ((r_q != j) ? cost_rd : '0);
	assign best_next = ((r_q == i_q) || (cost_c < best_q)) ? cost_c : best_q;

	obst_ram #(
		.WIDTH(COST_W),
		.DEPTH(CELLS)
	) u_cost_ram (
		.clk  (clk),
		.we   (cost_we),
		.waddr(cost_waddr),
		.wdata(cost_wdata),
		.raddr(cost_raddr),
		.rdata(cost_rd)
	);

	obst_ram #(
		.WIDTH(PREFIX_W),
		.DEPTH(MAX_KEYS)
	) u_prefix_ram (
		.clk  (clk),
		.we   (prefix_we),
		.waddr(key_idx),
		.wdata(prefix_wdata),
		.raddr(prefix_raddr),
		.rdata(prefix_rd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && last_key) begin
					state_d = (n_after == CNT_W'(1)) ? ST_FIN_RD : ST_W1;
				end
			end
			ST_W1: state_d = ST_W2;
			ST_W2: state_d = ST_RL;
			ST_RL: state_d = ST_RR;
			ST_RR: state_d = ST_RC;
			ST_RC: state_d = (r_q == j) ? ST_WR : ST_RR;
			ST_WR: begin
				if ((end_sum == count_q) && (len_q == count_q)) begin
					state_d = ST_FIN_RD;
				end else begin
					state_d = ST_W1;
				end
			end
			ST_FIN_RD: state_d = ST_FIN_OUT;
			ST_FIN_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cost_we = 1'b0;
		cost_waddr = cell_addr(key_idx, key_idx);
		cost_wdata = COST_W'(freq_used);
		cost_raddr = cell_addr(i_q, KEY_W'(r_q - KEY_W'(1)));
		prefix_we = 1'b0;
		prefix_wdata = sum_q + PREFIX_W'(freq_used);
		prefix_raddr = j;
		unique case (state_q)
			ST_IDLE: begin
				cost_we = accept && room;
				prefix_we = accept && room;
			end
			ST_W1: prefix_raddr = j;
			ST_W2: prefix_raddr = KEY_W'(i_q - KEY_W'(1));
			ST_RL: cost_raddr = cell_addr(i_q, KEY_W'(r_q - KEY_W'(1)));
			ST_RR: cost_raddr = cell_addr(KEY_W'(r_q + KEY_W'(1)), j);
			ST_RC: cost_raddr = cell_addr(i_q, r_q);
			ST_WR: begin
				cost_we = 1'b1;
				cost_waddr = cell_addr(i_q, j);
				cost_wdata = best_q + COST_W'(weight_q);
			end
			ST_FIN_RD: cost_raddr = cell_addr('0, KEY_W'(count_q - CNT_W'(1)));
			ST_FIN_OUT: cost_raddr = cell_addr(i_q, r_q);
			default: cost_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			sum_q <= '0;
			len_q <= '0;
			i_q <= '0;
			r_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (room) begin
							count_q <= n_after;
							sum_q <= prefix_wdata;
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_key) begin
							len_q <= CNT_W'(2);
							i_q <= '0;
						end
					end
				end
				ST_W1: r_q <= i_q;
				ST_RC: begin
					if (r_q != j) begin
						r_q <= KEY_W'(r_q + KEY_W'(1));
					end
				end
				ST_WR: begin
					if (end_sum == count_q) begin
						len_q <= len_q + CNT_W'(1);
						i_q <= '0;
					end else begin
						i_q <= KEY_W'(i_q + KEY_W'(1));
					end
				end
				ST_FIN_OUT: begin
					done_q <= 1'b1;
					count_q <= '0;
					ovf_q <= 1'b0;
					sum_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_W2: pj_q <= prefix_rd;
			ST_RL: weight_q <= pj_q - ((i_q != '0) ? prefix_rd : '0);
			ST_RR: left_q <= (r_q != i_q) ? cost_rd : '0;
			ST_RC: begin
				best_q <= best_next;
				left_q <= cost_rd;
			end
			ST_FIN_OUT: begin
				min_cost_q <= cost_rd;
				too_many_q <= ovf_q;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign min_cost = min_cost_q;
	assign too_many = too_many_q;

	`ASSERT_NEXT(a_done_follows_fin, clk, arst_n, state_q == ST_FIN_OUT, done)
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(MAX_KEYS))
	`ASSERT_ALWAYS(a_root_in_range, clk, arst_n, (state_q != ST_RC) || ((r_q >= i_q) && (r_q <= j)))

endmodule

### tb/sv/tb_optimal_bst_cost.sv
// Testbench for optimal_bst_cost: key sets are driven in and every reported cost is checked.
`timescale 1ns / 100ps

module tb_optimal_bst_cost;
	import obst_pkg::*;

	typedef logic [FREQ_IN_W-1:0] freq_word_t;

	typedef struct {
		cost_t cost;
		logic  overflow;
	} tree_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [FREQ_IN_W-1:0] freq_value;
	logic                 last_key;
	logic                 done;
	logic [COST_W-1:0]    min_cost;
	logic                 too_many;

	freq_word_t   loaded_keys[$];
	bit           keys_dropped;
	tree_result_t expected_results[$];
	int           mismatch_count;

	optimal_bst_cost dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.freq_value(freq_value),
		.last_key(last_key),
		.done(done),
		.min_cost(min_cost),
		.too_many(too_many)
	);

	always #4 clk = ~clk;

	function automatic cost_t optimal_tree_cost(input freq_word_t keys[$]);
		longint unsigned span_cost[MAX_KEYS][MAX_KEYS];
		longint unsigned prefix[MAX_KEYS+1];
		longint unsigned best;
		longint unsigned trial;
		int n;
		int hi;
		n = keys.size();
		prefix[0] = 0;
		for (int k = 0; k < n; k++) begin
			prefix[k+1] = prefix[k] + longint'(keys[k][FREQ_USED_W-1:0]);
			span_cost[k][k] = longint'(keys[k][FREQ_USED_W-1:0]);
		end
		for (int len = 2; len <= n; len++) begin
			for (int lo = 0; lo + len <= n; lo++) begin
				hi = lo + len - 1;
				best = 0;
				for (int root = lo; root <= hi; root++) begin
					trial = 0;
					if (root > lo)
						trial += span_cost[lo][root-1];
					if (root < hi)
						trial += span_cost[root+1][hi];
					if (root == lo || trial < best)
						best = trial;
				end
				span_cost[lo][hi] = best + prefix[hi+1] - prefix[lo];
			end
		end
		best = span_cost[0][n-1];
		if (best > longint'({COST_W{1'b1}}))
			best = longint'({COST_W{1'b1}});
		return cost_t'(best);
	endfunction

	task automatic report_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50)
			return 0;
		else if (sel < 90)
			return $urandom_range(3, 1);
		else
			return $urandom_range(40, 10);
	endfunction

	// Called just after a rising edge; returns just after the edge of the transfer.
	task automatic send_key(input freq_word_t freq, input bit last, input int gap);
		tree_result_t r;
		if (gap > 0) begin
			start <= 1'b0;
			freq_value <= freq_word_t'($urandom);
			last_key <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		freq_value <= freq;
		last_key <= last;
		do @(posedge clk); while (busy);
		if (loaded_keys.size() < MAX_KEYS)
			loaded_keys.push_back(freq);
		else
			keys_dropped = 1'b1;
		if (last) begin
			r.cost = optimal_tree_cost(loaded_keys);
			r.overflow = keys_dropped;
			expected_results.push_back(r);
			loaded_keys.delete();
			keys_dropped = 1'b0;
		end
	endtask

	task automatic send_set(input freq_word_t keys[$], input bit with_gaps);
		foreach (keys[k])
			send_key(keys[k], k == keys.size() - 1, with_gaps ? pick_gap() : 0);
	endtask

	task automatic test_single_keys();
		send_set({16'h0000}, 1'b0);
		send_set({16'hFFFF}, 1'b1);
	endtask

	task automatic test_small_sets();
		send_set({16'hFFFF, 16'h0000}, 1'b0);
		send_set({16'h0000, 16'hFFFF}, 1'b1);
		send_set({16'h0001, 16'h0002, 16'h0003}, 1'b0);
		send_set({16'h0005, 16'h0005, 16'h0005, 16'h0005}, 1'b1);
	endtask

	// The marked key is the first one past the table size, so it is itself dropped.
	task automatic test_overflow();
		freq_word_t keys[$];
		repeat (MAX_KEYS + 1)
			keys.push_back(16'hFFFF);
		send_set(keys, 1'b0);
	endtask

	task automatic test_random_sets(input int item_target);
		freq_word_t keys[$];
		int sent;
		int sel;
		int len;
		int style;
		sent = 0;
		while (sent < item_target) begin
			sel = $urandom_range(99);
			if (sel < 60)
				len = $urandom_range(6, 1);
			else if (sel < 85)
				len = $urandom_range(16, 7);
			else if (sel < 95)
				len = $urandom_range(MAX_KEYS, 17);
			else
				len = $urandom_range(MAX_KEYS + 8, MAX_KEYS + 1);
			style = $urandom_range(3);
			keys.delete();
			repeat (len) begin
				case (style)
					0: keys.push_back(freq_word_t'($urandom));
					1: keys.push_back(freq_word_t'($urandom_range(3)));
					2: keys.push_back($urandom_range(1) ? 16'hFFFF : 16'h0000);
					default: keys.push_back($urandom_range(1) ? freq_word_t'($urandom)
						: freq_word_t'($urandom_range(15)));
				endcase
			end
			send_set(keys, $urandom_range(3) != 0);
			sent += len;
		end
	endtask

	always @(posedge clk) begin
		tree_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_failure($sformatf("unexpected result: cost %0d too_many %0b",
					min_cost, too_many));
			end else begin
				want = expected_results.pop_front();
				if (min_cost !== want.cost)
					report_failure($sformatf("min_cost expected %0d actual %0d",
						want.cost, min_cost));
				if (too_many !== want.overflow)
					report_failure($sformatf("too_many expected %0b actual %0b",
						want.overflow, too_many));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		freq_value = '0;
		last_key = 1'b0;
		mismatch_count = 0;
		keys_dropped = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_keys();
		test_small_sets();
		test_overflow();
		test_random_sets(1550);
		start <= 1'b0;
		for (int w = 0; w < 50000 && expected_results.size() != 0; w++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			report_failure($sformatf("%0d results never arrived", expected_results.size()));
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
